/* rtl/core/rgbega_pkg.sv */
package rgbega_pkg;

    localparam int PalCount = 16;
    localparam int LvlCount = 4;
    localparam int ChanW    = 8;
    localparam int SqW      = 2 * ChanW;
    localparam int DistW    = SqW + 2;
    localparam int IdxW     = 4;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic [SqW-1:0]   t_sq;
    typedef logic [DistW-1:0] t_dist;
    typedef logic [IdxW-1:0]  t_idx;
    typedef logic [1:0]       t_lvl;

    localparam t_lvl LvlZero = 2'd0;
    localparam t_lvl LvlLo   = 2'd1;
    localparam t_lvl LvlMid  = 2'd2;
    localparam t_lvl LvlHi   = 2'd3;

    localparam t_chan LevelVal [LvlCount] = '{8'd0, 8'd85, 8'd170, 8'd255};

    typedef struct packed {
        t_lvl r;
        t_lvl g;
        t_lvl b;
    } t_pal_ent;

    localparam t_pal_ent Palette [PalCount] = '{
        '{LvlZero, LvlZero, LvlZero},
        '{LvlZero, LvlZero, LvlMid },
        '{LvlZero, LvlMid,  LvlZero},
        '{LvlZero, LvlMid,  LvlMid },
        '{LvlMid,  LvlZero, LvlZero},
        '{LvlMid,  LvlZero, LvlMid },
        '{LvlMid,  LvlLo,   LvlZero},
        '{LvlMid,  LvlMid,  LvlMid },
        '{LvlLo,   LvlLo,   LvlLo  },
        '{LvlLo,   LvlLo,   LvlHi  },
        '{LvlLo,   LvlHi,   LvlLo  },
        '{LvlLo,   LvlHi,   LvlHi  },
        '{LvlHi,   LvlLo,   LvlLo  },
        '{LvlHi,   LvlLo,   LvlHi  },
        '{LvlHi,   LvlHi,   LvlLo  },
        '{LvlHi,   LvlHi,   LvlHi  }
    };

endpackage

/* rtl/core/rgb_to_nearest_ega_index_unit.sv */
// Maps one RGB888 pixel to the index of the nearest color of the 16-entry
// default EGA palette (squared Euclidean distance, lowest index on ties).
// A pixel is taken at every clock edge with start high; busy never rises,
// so one pixel per cycle is sustained. Each result appears on
// o_palette_index for exactly one cycle with o_valid high; between the
// pixel and its result, two stages form the channel squares and the
// per-entry sums, three stages reduce the sixteen distances through a
// compare tree. The receiver cannot stall; results come out in input order.
module rgb_to_nearest_ega_index_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbega_pkg::t_chan   i_red,
    input  rgbega_pkg::t_chan   i_green,
    input  rgbega_pkg::t_chan   i_blue,
    output logic                o_valid,
    output rgbega_pkg::t_idx    o_palette_index
);

    logic              dist_valid;
    rgbega_pkg::t_dist pal_dist [rgbega_pkg::PalCount];

    assign busy = 1'b0;

    rgbega_sqdist u_sqdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (dist_valid),
        .o_dist  (pal_dist)
    );

    rgbega_argmin u_argmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .i_dist  (pal_dist),
        .o_valid (o_valid),
        .o_idx   (o_palette_index)
    );

    a_strobe_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 5))
        else $error("result strobe without a beat five cycles earlier");

    a_beat_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start, 5) && $past(i_rst_n, 5) && $past(i_rst_n, 4) && $past(i_rst_n, 3)
         && $past(i_rst_n, 2) && $past(i_rst_n, 1)) |-> o_valid)
        else $error("accepted beat produced no result");

    a_black_maps_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_red == 8'd0 && i_green == 8'd0 && i_blue == 8'd0, 5))
        |-> (o_palette_index == 4'd0))
        else $error("black pixel not mapped to entry zero");

    a_white_maps_to_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_red == 8'd255 && i_green == 8'd255 && i_blue == 8'd255, 5))
        |-> (o_palette_index == 4'd15))
        else $error("white pixel not mapped to entry fifteen");

endmodule

/* rtl/core/rgbega_sqdist.sv */
module rgbega_sqdist (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rgbega_pkg::t_chan   i_red,
    input  rgbega_pkg::t_chan   i_green,
    input  rgbega_pkg::t_chan   i_blue,
    output logic                o_valid,
    output rgbega_pkg::t_dist   o_dist [rgbega_pkg::PalCount]
);

    logic              r_v1;
    logic              r_v2;
    rgbega_pkg::t_sq   r_sq   [3][rgbega_pkg::LvlCount];
    rgbega_pkg::t_sq   n_sq   [3][rgbega_pkg::LvlCount];
    rgbega_pkg::t_dist r_dist [rgbega_pkg::PalCount];
    rgbega_pkg::t_dist n_dist [rgbega_pkg::PalCount];

    // stage 1: squared distance of each channel to each of the four levels
    always_comb begin
        rgbega_pkg::t_chan ch [3];
        rgbega_pkg::t_chan lv;
        rgbega_pkg::t_chan d;
        ch[0] = i_red;
        ch[1] = i_green;
        ch[2] = i_blue;
        for (int c = 0; c < 3; c++) begin
            for (int l = 0; l < rgbega_pkg::LvlCount; l++) begin
                lv = rgbega_pkg::LevelVal[l];
                d  = (ch[c] > lv) ? ch[c] - lv : lv - ch[c];
                n_sq[c][l] = rgbega_pkg::t_sq'(d) * rgbega_pkg::t_sq'(d);
            end
        end
    end

    // stage 2: per-entry sum of three channel terms
    always_comb begin
        for (int k = 0; k < rgbega_pkg::PalCount; k++) begin
            n_dist[k] = rgbega_pkg::t_dist'(r_sq[0][rgbega_pkg::Palette[k].r])
                      + rgbega_pkg::t_dist'(r_sq[1][rgbega_pkg::Palette[k].g])
                      + rgbega_pkg::t_dist'(r_sq[2][rgbega_pkg::Palette[k].b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_sq   <= n_sq;
        r_dist <= n_dist;
    end

    assign o_valid = r_v2;
    assign o_dist  = r_dist;

endmodule

/* rtl/core/rgbega_argmin.sv */
module rgbega_argmin (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rgbega_pkg::t_dist   i_dist [rgbega_pkg::PalCount],
    output logic                o_valid,
    output rgbega_pkg::t_idx    o_idx
);

    typedef struct packed {
        rgbega_pkg::t_dist cost;
        rgbega_pkg::t_idx  idx;
    } t_cand;

    // left operand holds the lower indices; it keeps ties
    function automatic t_cand pick(t_cand a, t_cand b);
        return (b.cost < a.cost) ? b : a;
    endfunction

    logic             r_va;
    logic             r_vb;
    logic             r_vc;
    t_cand            r_a [8];
    t_cand            n_a [8];
    t_cand            r_b [2];
    t_cand            n_b [2];
    rgbega_pkg::t_idx r_idx;
    t_cand            n_c;

    always_comb begin
        t_cand lo;
        t_cand hi;
        for (int j = 0; j < 8; j++) begin
            lo.cost = i_dist[2*j];
            lo.idx  = rgbega_pkg::t_idx'(2*j);
            hi.cost = i_dist[2*j+1];
            hi.idx  = rgbega_pkg::t_idx'(2*j+1);
            n_a[j]  = pick(lo, hi);
        end
    end

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            n_b[m] = pick(pick(r_a[4*m], r_a[4*m+1]), pick(r_a[4*m+2], r_a[4*m+3]));
        end
    end

    assign n_c = pick(r_b[0], r_b[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_idx <= n_c.idx;
    end

    assign o_valid = r_vc;
    assign o_idx   = r_idx;

endmodule
